>>> hdl/assert_macros.svh
// assertion macros shared by the fetcher rtl
// expects clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define FFET_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define FFET_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/ffet_pkg.sv
// shared types, codes and constants of the named file fetcher
// no dependencies
package ffet_pkg;

  localparam int MAX_FILES_DEF   = 32;
  localparam int MAX_PAYLOAD_DEF = 4096;

  localparam int NAME_STORE  = 55;
  localparam int NAME_FIELD  = 56;

  localparam logic [13:0] KEY_SIG  = 14'h0000;
  localparam logic [13:0] KEY_FEAT = 14'h0001;
  localparam logic [13:0] KEY_DIR  = 14'h0019;
  localparam logic [15:0] KEY_LOW   = 16'h0020;
  localparam logic [15:0] KEY_LIMIT = 16'h4000;

  // signature bytes 'Q' 'E' 'M' 'U', big-endian
  localparam logic [31:0] SIG_WORD  = {8'h51, 8'h45, 8'h4D, 8'h55};
  localparam logic [31:0] FEAT_WORD = 32'h0100_0000;

  typedef enum logic [1:0] {
    CMD_BEGIN = 2'd0,
    CMD_NAME  = 2'd1,
    CMD_DATA  = 2'd2,
    CMD_FAIL  = 2'd3
  } cmd_code_t;

  typedef enum logic [1:0] {
    ACT_SELECT  = 2'd0,
    ACT_PAYLOAD = 2'd1,
    ACT_DONE    = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FORMAT    = 3'd1,
    ST_IO        = 3'd2,
    ST_DEVICE    = 3'd3,
    ST_FEATURES  = 3'd4,
    ST_DIRECTORY = 3'd5,
    ST_MISSING   = 3'd6,
    ST_LENGTH    = 3'd7
  } status_t;

  typedef struct packed {
    action_t     action;
    logic [13:0] key;
    logic [7:0]  data_byte;
    status_t     status;
    logic        last;
  } out_beat_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic exec;
    logic walk_cmp;
    logic emit_fin;
  } ffet_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic walk_need;
    logic two_results;
    logic walk_last;
  } ffet_sts_t;

  function automatic out_beat_t mk_done(status_t st);
    out_beat_t b;
    b.action    = ACT_DONE;
    b.key       = '0;
    b.data_byte = '0;
    b.status    = st;
    b.last      = 1'b1;
    return b;
  endfunction

  function automatic out_beat_t mk_select(logic [13:0] k);
    out_beat_t b;
    b.action    = ACT_SELECT;
    b.key       = k;
    b.data_byte = '0;
    b.status    = ST_OK;
    b.last      = 1'b1;
    return b;
  endfunction

endpackage

>>> hdl/ffet_if.sv
// valid/ready channel interfaces for request and result beats
// depends on nothing
interface ffet_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [7:0]  value;
  logic [12:0] want_length;
  modport source (output valid, cmd, value, want_length, input ready);
  modport sink   (input valid, cmd, value, want_length, output ready);
endinterface

interface ffet_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [13:0] key;
  logic [7:0]  data_byte;
  logic [2:0]  status;
  logic        last;
  modport source (output valid, action, key, data_byte, status, last, input ready);
  modport sink   (input valid, action, key, data_byte, status, last, output ready);
endinterface

>>> hdl/ffet_ctrl.sv
// cycle sequencer of the fetcher: accept, execute, key walk, second result
// depends on ffet_pkg
module ffet_ctrl
  import ffet_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  ffet_sts_t sts,
  output ffet_cmd_t cmd
);

  typedef enum logic [4:0] {
    C_ACCEPT = 5'b00001,
    C_EXEC   = 5'b00010,
    C_WRD    = 5'b00100,
    C_WCMP   = 5'b01000,
    C_FIN    = 5'b10000
  } cstate_t;

  cstate_t state_r, state_nxt;

  assign in_ready = (state_r == C_ACCEPT) && sts.out_free;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    unique case (state_r)
      C_ACCEPT: begin
        if (in_valid && in_ready) begin
          cmd.latch = 1'b1;
          state_nxt = C_EXEC;
        end
      end
      C_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.walk_need)        state_nxt = C_WRD;
        else if (sts.two_results) state_nxt = C_FIN;
        else                      state_nxt = C_ACCEPT;
      end
      C_WRD: state_nxt = C_WCMP;
      C_WCMP: begin
        cmd.walk_cmp = 1'b1;
        state_nxt    = sts.walk_last ? C_ACCEPT : C_WRD;
      end
      C_FIN: begin
        if (sts.out_free) begin
          cmd.emit_fin = 1'b1;
          state_nxt    = C_ACCEPT;
        end
      end
      default: state_nxt = C_ACCEPT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= C_ACCEPT;
    else        state_r <= state_nxt;
  end

endmodule

>>> hdl/ffet_dp.sv
// datapath of the fetcher: request state, name and seen-key memories,
// directory checks and the result register; depends on ffet_pkg
module ffet_dp
  import ffet_pkg::*;
#(
  parameter int MAX_FILES   = MAX_FILES_DEF,
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_value,
  input  logic [12:0] in_want_length,
  input  logic        out_ready,
  output logic        out_valid,
  output out_beat_t   out_beat,
  input  ffet_cmd_t   cmd,
  output ffet_sts_t   sts
);

  localparam int AW = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
  localparam int IW = $clog2(MAX_FILES + 1);

  typedef enum logic [6:0] {
    PH_IDLE    = 7'b0000001,
    PH_NAME    = 7'b0000010,
    PH_SIG     = 7'b0000100,
    PH_FEAT    = 7'b0001000,
    PH_COUNT   = 7'b0010000,
    PH_ENTRY   = 7'b0100000,
    PH_PAYLOAD = 7'b1000000
  } phase_t;

  // latched beat
  cmd_code_t   it_cmd_r;
  logic [7:0]  it_val_r;
  logic [12:0] it_wl_r;

  phase_t      phase_r, phase_nxt;
  logic [5:0]  name_len_r, name_len_nxt;
  logic [12:0] want_len_r, want_len_nxt;
  logic [5:0]  byte_pos_r, byte_pos_nxt;
  logic [31:0] hdr_r, hdr_nxt;
  logic [IW-1:0] tot_r, tot_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [31:0] esize_r, esize_nxt;
  logic [15:0] ekey_r, ekey_nxt;
  logic [5:0]  enlen_r, enlen_nxt;
  logic        fmatch_r, fmatch_nxt;
  logic        fended_r, fended_nxt;
  logic        fbad_r, fbad_nxt;
  logic [13:0] ckey_r, ckey_nxt;
  logic [31:0] csize_r, csize_nxt;
  logic [12:0] left_r, left_nxt;
  logic [IW-1:0] walk_j_r, walk_j_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_beat_t   out_r, out_nxt;

  // memories
  logic [7:0]  name_mem [NAME_STORE];
  logic [13:0] seen_mem [MAX_FILES];
  logic        name_we;
  logic [5:0]  name_waddr;
  logic [5:0]  name_raddr;
  logic [5:0]  pos_idx;
  logic [7:0]  name_rd_r;
  logic        seen_we;
  logic [13:0] seen_rd_r;

  // name byte compared during execute is fetched during accept
  assign pos_idx    = byte_pos_r - 6'd8;
  assign name_raddr = (pos_idx < 6'(NAME_STORE)) ? pos_idx : '0;

  always_ff @(posedge clk) begin
    if (name_we) name_mem[name_waddr] <= it_val_r;
    name_rd_r <= name_mem[name_raddr];
  end

  always_ff @(posedge clk) begin
    if (seen_we) seen_mem[idx_r[AW-1:0]] <= ekey_nxt[13:0];
    seen_rd_r <= seen_mem[walk_j_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      it_cmd_r <= cmd_code_t'(in_cmd);
      it_val_r <= in_value;
      it_wl_r  <= in_want_length;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_beat      = out_r;

  always_comb begin
    logic        e_match, e_ended, e_bad, e_bad2;
    logic [5:0]  e_nlen, nidx;
    logic [IW-1:0] idx_inc;
    logic [12:0] left_dec;

    phase_nxt    = phase_r;
    name_len_nxt = name_len_r;
    want_len_nxt = want_len_r;
    byte_pos_nxt = byte_pos_r;
    hdr_nxt      = hdr_r;
    tot_nxt      = tot_r;
    idx_nxt      = idx_r;
    esize_nxt    = esize_r;
    ekey_nxt     = ekey_r;
    enlen_nxt    = enlen_r;
    fmatch_nxt   = fmatch_r;
    fended_nxt   = fended_r;
    fbad_nxt     = fbad_r;
    ckey_nxt     = ckey_r;
    csize_nxt    = csize_r;
    left_nxt     = left_r;
    walk_j_nxt   = walk_j_r;
    out_nxt      = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    name_we      = 1'b0;
    name_waddr   = name_len_r;
    seen_we      = 1'b0;
    sts.out_free    = !out_valid_r;
    sts.walk_last   = (IW'(walk_j_r + 1'b1) == idx_r);
    sts.walk_need   = 1'b0;
    sts.two_results = 1'b0;
    e_match = fmatch_r;
    e_ended = fended_r;
    e_bad   = fbad_r;
    e_bad2  = 1'b0;
    e_nlen  = enlen_r;
    nidx    = pos_idx;
    idx_inc = IW'(idx_r + 1'b1);
    left_dec = (left_r != '0) ? left_r - 13'd1 : left_r;

    if (cmd.emit_fin) begin
      out_nxt       = mk_done(ST_OK);
      out_valid_nxt = 1'b1;
    end

    if (cmd.walk_cmp) begin
      if ({2'b00, seen_rd_r} == ekey_r) fbad_nxt = 1'b1;
      walk_j_nxt = IW'(walk_j_r + 1'b1);
    end

    if (cmd.exec) begin
      walk_j_nxt = '0;
      unique case (it_cmd_r)
        CMD_BEGIN: begin
          phase_nxt    = PH_NAME;
          want_len_nxt = it_wl_r;
          name_len_nxt = '0;
        end
        CMD_NAME: begin
          if (phase_r == PH_NAME) begin
            if (it_val_r != 8'd0) begin
              name_we = (name_len_r < 6'(NAME_STORE));
              if (name_len_r < 6'(NAME_FIELD)) name_len_nxt = name_len_r + 6'd1;
            end else if (want_len_r == '0 || 32'(want_len_r) > 32'(MAX_PAYLOAD) ||
                         name_len_r == '0 || name_len_r >= 6'(NAME_FIELD)) begin
              phase_nxt = PH_IDLE;
              out_nxt = mk_done(ST_FORMAT);
              out_valid_nxt = 1'b1;
            end else begin
              phase_nxt = PH_SIG;
              byte_pos_nxt = '0;
              hdr_nxt = '0;
              out_nxt = mk_select(KEY_SIG);
              out_valid_nxt = 1'b1;
            end
          end
        end
        CMD_FAIL: begin
          if (phase_r != PH_IDLE && phase_r != PH_NAME) begin
            phase_nxt = PH_IDLE;
            out_nxt = mk_done(ST_IO);
            out_valid_nxt = 1'b1;
          end
        end
        CMD_DATA: begin
          if (phase_r == PH_ENTRY) begin
            // directory entry byte
            byte_pos_nxt = byte_pos_r + 6'd1;
            if (byte_pos_r < 6'd4) begin
              esize_nxt = {esize_r[23:0], it_val_r};
            end else if (byte_pos_r < 6'd6) begin
              ekey_nxt = {ekey_r[7:0], it_val_r};
              if (byte_pos_r == 6'd5) begin
                if (ekey_nxt < KEY_LOW || ekey_nxt >= KEY_LIMIT) fbad_nxt = 1'b1;
                seen_we = 1'b1;
                sts.walk_need = (idx_r != '0);
              end
            end else if (byte_pos_r < 6'd8) begin
              if (it_val_r != 8'd0) fbad_nxt = 1'b1;
            end else if (!fended_r) begin
              if (it_val_r == 8'd0) begin
                e_ended = 1'b1;
                e_nlen  = nidx;
              end else if (nidx >= name_len_r || nidx >= 6'(NAME_STORE) ||
                           name_rd_r != it_val_r) begin
                e_match = 1'b0;
              end
              fended_nxt = e_ended;
              enlen_nxt  = e_nlen;
              fmatch_nxt = e_match;
            end

            if (byte_pos_r == 6'd63) begin
              e_bad2 = e_bad || !e_ended || e_nlen == '0;
              if (!e_bad2 && e_match && e_nlen == name_len_r) begin
                if (ckey_r != '0) e_bad2 = 1'b1;
                else begin
                  ckey_nxt  = ekey_r[13:0];
                  csize_nxt = esize_r;
                end
              end
              if (e_bad2) begin
                phase_nxt = PH_IDLE;
                out_nxt = mk_done(ST_DIRECTORY);
                out_valid_nxt = 1'b1;
              end else begin
                idx_nxt = idx_inc;
                if (idx_inc < tot_r) begin
                  byte_pos_nxt = '0;
                  esize_nxt  = '0;
                  ekey_nxt   = '0;
                  enlen_nxt  = '0;
                  fmatch_nxt = 1'b1;
                  fended_nxt = 1'b0;
                  fbad_nxt   = 1'b0;
                end else if (ckey_nxt == '0) begin
                  phase_nxt = PH_IDLE;
                  out_nxt = mk_done(ST_MISSING);
                  out_valid_nxt = 1'b1;
                end else if (csize_nxt != 32'(want_len_r)) begin
                  phase_nxt = PH_IDLE;
                  out_nxt = mk_done(ST_LENGTH);
                  out_valid_nxt = 1'b1;
                end else begin
                  left_nxt = want_len_r;
                  phase_nxt = PH_PAYLOAD;
                  byte_pos_nxt = '0;
                  hdr_nxt = '0;
                  out_nxt = mk_select(ckey_nxt);
                  out_valid_nxt = 1'b1;
                end
              end
            end
          end else if (phase_r == PH_PAYLOAD) begin
            left_nxt = left_dec;
            out_nxt.action    = ACT_PAYLOAD;
            out_nxt.key       = '0;
            out_nxt.data_byte = it_val_r;
            out_nxt.status    = ST_OK;
            out_nxt.last      = (left_dec != '0);
            out_valid_nxt     = 1'b1;
            if (left_dec == '0) begin
              phase_nxt       = PH_IDLE;
              sts.two_results = 1'b1;
            end
          end else if (phase_r == PH_SIG || phase_r == PH_FEAT ||
                       phase_r == PH_COUNT) begin
            // four-byte big-endian header word
            hdr_nxt      = {hdr_r[23:0], it_val_r};
            byte_pos_nxt = byte_pos_r + 6'd1;
            if (byte_pos_r == 6'd3) begin
              byte_pos_nxt = '0;
              priority if (phase_r == PH_SIG) begin
                if (hdr_nxt != SIG_WORD) begin
                  phase_nxt = PH_IDLE;
                  out_nxt = mk_done(ST_DEVICE);
                end else begin
                  phase_nxt = PH_FEAT;
                  hdr_nxt = '0;
                  out_nxt = mk_select(KEY_FEAT);
                end
                out_valid_nxt = 1'b1;
              end else if (phase_r == PH_FEAT) begin
                if (hdr_nxt != FEAT_WORD) begin
                  phase_nxt = PH_IDLE;
                  out_nxt = mk_done(ST_FEATURES);
                end else begin
                  phase_nxt = PH_COUNT;
                  hdr_nxt = '0;
                  out_nxt = mk_select(KEY_DIR);
                end
                out_valid_nxt = 1'b1;
              end else begin
                if (hdr_nxt > 32'(MAX_FILES)) begin
                  phase_nxt = PH_IDLE;
                  out_nxt = mk_done(ST_DIRECTORY);
                  out_valid_nxt = 1'b1;
                end else begin
                  tot_nxt   = hdr_nxt[IW-1:0];
                  idx_nxt   = '0;
                  ckey_nxt  = '0;
                  csize_nxt = '0;
                  if (hdr_nxt == '0) begin
                    phase_nxt = PH_IDLE;
                    out_nxt = mk_done(ST_MISSING);
                    out_valid_nxt = 1'b1;
                  end else begin
                    phase_nxt  = PH_ENTRY;
                    esize_nxt  = '0;
                    ekey_nxt   = '0;
                    enlen_nxt  = '0;
                    fmatch_nxt = 1'b1;
                    fended_nxt = 1'b0;
                    fbad_nxt   = 1'b0;
                  end
                end
              end
            end
          end
        end
        default: phase_nxt = phase_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      name_len_r  <= '0;
      want_len_r  <= '0;
      byte_pos_r  <= '0;
      hdr_r       <= '0;
      tot_r       <= '0;
      idx_r       <= '0;
      esize_r     <= '0;
      ekey_r      <= '0;
      enlen_r     <= '0;
      fmatch_r    <= 1'b0;
      fended_r    <= 1'b0;
      fbad_r      <= 1'b0;
      ckey_r      <= '0;
      csize_r     <= '0;
      left_r      <= '0;
      walk_j_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      name_len_r  <= name_len_nxt;
      want_len_r  <= want_len_nxt;
      byte_pos_r  <= byte_pos_nxt;
      hdr_r       <= hdr_nxt;
      tot_r       <= tot_nxt;
      idx_r       <= idx_nxt;
      esize_r     <= esize_nxt;
      ekey_r      <= ekey_nxt;
      enlen_r     <= enlen_nxt;
      fmatch_r    <= fmatch_nxt;
      fended_r    <= fended_nxt;
      fbad_r      <= fbad_nxt;
      ckey_r      <= ckey_nxt;
      csize_r     <= csize_nxt;
      left_r      <= left_nxt;
      walk_j_r    <= walk_j_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

endmodule

>>> hdl/fwcfg_named_file_fetcher.sv
// Named-file fetcher for a firmware-configuration port, top level.
// A request is a begin beat carrying the wanted length, then the name one byte
// per beat ending in a zero byte; port bytes and port failures follow as beats.
// Results are select-key, payload-byte and finished beats, the last carrying the
// status. Every input beat is accepted, then executed, while the result register
// is free; the beat that completes a directory entry's key adds one read and one
// compare of the seen-key memory per earlier entry. The last payload byte yields
// two results, the finished beat leaving once the byte has been taken. Input is
// held off while a result waits. Memories need no clearing pass after reset.
// Depends on ffet_pkg, ffet_if, ffet_ctrl, ffet_dp and assert_macros.svh.
`include "assert_macros.svh"

module fwcfg_named_file_fetcher
  import ffet_pkg::*;
#(
  parameter int MAX_FILES   = MAX_FILES_DEF,
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ffet_in_if.sink    in_ch,
  ffet_out_if.source out_ch
);

  ffet_cmd_t cmd;
  ffet_sts_t sts;
  out_beat_t beat;
  logic      out_valid;

  // sequencer: decides which cycle does what
  ffet_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // request state, memories and the result register
  ffet_dp #(
    .MAX_FILES   (MAX_FILES),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_cmd         (in_ch.cmd),
    .in_value       (in_ch.value),
    .in_want_length (in_ch.want_length),
    .out_ready      (out_ch.ready),
    .out_valid      (out_valid),
    .out_beat       (beat),
    .cmd            (cmd),
    .sts            (sts)
  );

  // result beat fields
  assign out_ch.valid     = out_valid;
  assign out_ch.action    = beat.action;
  assign out_ch.key       = beat.key;
  assign out_ch.data_byte = beat.data_byte;
  assign out_ch.status    = beat.status;
  assign out_ch.last      = beat.last;

  // no input beat while a result is pending
  `FFET_ASSERT(a_accept_free, in_ch.valid && in_ch.ready |-> !out_ch.valid, "beat accepted over pending result")
  // every accepted beat is executed in the next cycle
  `FFET_ASSERT(a_exec_follows, in_ch.valid && in_ch.ready |=> cmd.exec, "accepted beat not executed")
  // a new result only comes from execute or the second-result step
  `FFET_ASSERT(a_out_source, $rose(out_ch.valid) |-> $past(cmd.exec || cmd.emit_fin), "result without cause")
  // reset empties the result register
  `FFET_ASSERT_ALWAYS(a_reset_out, !rst_n |=> !out_ch.valid, "result valid after reset")

endmodule
